### src/round_robin_thread_dispatcher_top_defines.svh
// Assertion macros used by the dispatcher datapath.
`ifndef ROUND_ROBIN_THREAD_DISPATCHER_TOP_DEFINES_SVH
`define ROUND_ROBIN_THREAD_DISPATCHER_TOP_DEFINES_SVH
`ifndef SYNTH
`define RRTD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RRTD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RRTD_ASSERT_ALWAYS(lbl, cond, msg)
`define RRTD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### src/rrtd_pkg.sv
package rrtd_pkg;

    localparam int NUM_CPUS    = 4;
    localparam int NUM_THREADS = 32;
    localparam int WAKE_BATCH  = 16;

    localparam int CPU_W      = 2;
    localparam int THR_W      = 5;
    localparam int PTR_W      = 6;
    localparam int LEN_W      = 6;
    localparam int Q_W        = 8;
    localparam int ST_W       = 3;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 5;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [Q_W-1:0] QUANTUM_RESET = 8'd4;
    localparam logic [3:0]     ONLINE_RESET  = 4'b0001;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAKE   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TERM   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NONE   = 3'd7;

    localparam logic [ST_W-1:0] ST_NEW   = 3'd0;
    localparam logic [ST_W-1:0] ST_READY = 3'd1;
    localparam logic [ST_W-1:0] ST_RUN   = 3'd2;
    localparam logic [ST_W-1:0] ST_WAIT  = 3'd3;
    localparam logic [ST_W-1:0] ST_TERM  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DECODE,
        OP_CREATE,
        OP_MKRDY,
        OP_LINK,
        OP_EVAL,
        OP_BLKLINK,
        OP_POP,
        OP_SETRUN,
        OP_PUSHCUR,
        OP_SCAN,
        OP_UNP,
        OP_UNN,
        OP_OUTLOAD
    } op_t;

    typedef struct packed {
        op_t  op;
        logic chk;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             mk_go;
        logic             online;
        logic             eval_swap;
        logic             eval_blk;
        logic             pop_same;
        logic             stays;
        logic             scan_end;
        logic             scan_match;
        logic             wall;
        logic             out_busy;
    } dp_stat_t;

endpackage

### src/rrtd_cmd_if.sv
interface rrtd_cmd_if import rrtd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [CPU_W-1:0]        cpu;
    logic [THR_W-1:0]        thread;
    logic signed [2:0]       affinity;
    logic [TAG_W-1:0]        wait_tag;
    logic                    wake_every;

    modport source (output valid, cmd, cpu, thread, affinity, wait_tag, wake_every,
                    input ready);
    modport sink (input valid, cmd, cpu, thread, affinity, wait_tag, wake_every,
                  output ready);
endinterface

### src/rrtd_res_if.sv
interface rrtd_res_if import rrtd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic             switched;
    logic [THR_W-1:0] prev_thread;
    logic [THR_W-1:0] next_thread;
    logic [CPU_W-1:0] chosen_cpu;
    logic [CNT_W-1:0] woken_count;
    logic             can_block;

    modport source (output valid, status, switched, prev_thread, next_thread,
                    chosen_cpu, woken_count, can_block, input ready);
    modport sink (input valid, status, switched, prev_thread, next_thread,
                  chosen_cpu, woken_count, can_block, output ready);
endinterface

### src/round_robin_thread_dispatcher_top.sv
// Channel   Role    Payload
// cmd_ch    sink    cmd, cpu, thread, affinity, wait_tag, wake_every
// res_ch    source  status, switched, prev_thread, next_thread, chosen_cpu,
//                   woken_count, can_block
// cfg port  write   cfg_we, cfg_index, cfg_data (no read-back)
//
// One command is handled at a time; a transfer on cmd_ch is taken only when the
// sequencer is idle. A wake scans the wait list waiter by waiter (at most 32
// scanned, at most 16 released) and releases each match, stopping at the first
// one unless wake_every is set; every command is paced by the serial walk
// through the thread tables.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled res_ch holds the result while the next command is already taken.
module round_robin_thread_dispatcher_top import rrtd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rrtd_cmd_if.sink              cmd_ch,
    rrtd_res_if.source            res_ch
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // The controller sequences the steps of each command; the datapath holds
    // the queues, the wait list and the thread tables.
    rrtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (cmd_ch.ready),
        .ctl      (ctl),
        .stat     (stat)
    );

    rrtd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_cmd        (cmd_ch.cmd),
        .in_cpu        (cmd_ch.cpu),
        .in_thread     (cmd_ch.thread),
        .in_affinity   (cmd_ch.affinity),
        .in_wait_tag   (cmd_ch.wait_tag),
        .in_wake_every (cmd_ch.wake_every),
        .out_ready     (res_ch.ready),
        .out_valid     (res_ch.valid),
        .out_status    (res_ch.status),
        .out_switched  (res_ch.switched),
        .out_prev      (res_ch.prev_thread),
        .out_next      (res_ch.next_thread),
        .out_target    (res_ch.chosen_cpu),
        .out_woken     (res_ch.woken_count),
        .out_can_block (res_ch.can_block)
    );

endmodule

### src/rrtd_ctrl.sv
module rrtd_ctrl import rrtd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  ctl,
    input  dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_CREATE, S_RDY_MK, S_RDY_LINK, S_SCAN, S_UNP, S_UNN,
        S_WK_MK, S_WK_LINK, S_EVAL, S_BLKLINK, S_POP, S_SETRUN, S_PUSHCUR,
        S_CURLINK, S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl.chk = 1'b0;
        ctl.op  = OP_NOP;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.op = OP_DECODE;
                case (stat.cmd)
                    CMD_CREATE: state_next = S_CREATE;
                    CMD_READY:  state_next = S_RDY_MK;
                    CMD_WAKE:   state_next = S_SCAN;
                    CMD_NONE:   state_next = S_DONE;
                    default:    state_next = S_EVAL;
                endcase
            end
            S_CREATE:
            begin
                ctl.op = OP_CREATE;
                state_next = S_DONE;
            end
            S_RDY_MK:
            begin
                ctl.op  = OP_MKRDY;
                ctl.chk = 1'b1;
                state_next = stat.mk_go ? S_RDY_LINK : S_DONE;
            end
            S_RDY_LINK:
            begin
                ctl.op = OP_LINK;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                ctl.op = OP_SCAN;
                if (stat.scan_end)
                    state_next = S_DONE;
                else if (stat.scan_match)
                    state_next = S_UNP;
            end
            S_UNP:
            begin
                ctl.op = OP_UNP;
                state_next = S_UNN;
            end
            S_UNN:
            begin
                ctl.op = OP_UNN;
                state_next = S_WK_MK;
            end
            S_WK_MK:
            begin
                ctl.op = OP_MKRDY;
                state_next = S_WK_LINK;
            end
            S_WK_LINK:
            begin
                ctl.op = OP_LINK;
                state_next = stat.wall ? S_SCAN : S_DONE;
            end
            S_EVAL:
            begin
                ctl.op = OP_EVAL;
                if (!stat.online)
                    state_next = S_DONE;
                else if (stat.eval_blk)
                    state_next = S_BLKLINK;
                else if (stat.eval_swap)
                    state_next = S_POP;
                else
                    state_next = S_DONE;
            end
            S_BLKLINK:
            begin
                ctl.op = OP_BLKLINK;
                state_next = S_POP;
            end
            S_POP:
            begin
                ctl.op = OP_POP;
                state_next = stat.pop_same ? S_DONE : S_SETRUN;
            end
            S_SETRUN:
            begin
                ctl.op = OP_SETRUN;
                state_next = stat.stays ? S_PUSHCUR : S_DONE;
            end
            S_PUSHCUR:
            begin
                ctl.op = OP_PUSHCUR;
                state_next = S_CURLINK;
            end
            S_CURLINK:
            begin
                ctl.op = OP_LINK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.op = OP_OUTLOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### src/rrtd_dp.sv
`include "round_robin_thread_dispatcher_top_defines.svh"
module rrtd_dp import rrtd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               ctl,
    output dp_stat_t              stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [CPU_W-1:0]      in_cpu,
    input  logic [THR_W-1:0]      in_thread,
    input  logic signed [2:0]     in_affinity,
    input  logic [TAG_W-1:0]      in_wait_tag,
    input  logic                  in_wake_every,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_status,
    output logic                  out_switched,
    output logic [THR_W-1:0]      out_prev,
    output logic [THR_W-1:0]      out_next,
    output logic [CPU_W-1:0]      out_target,
    output logic [CNT_W-1:0]      out_woken,
    output logic                  out_can_block
);

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_THREADS);

    // Configuration
    logic [Q_W-1:0] qrel_reg;
    logic [3:0]     mask_reg;
    logic           act_reg;

    // Per-thread tables, one access address per cycle
    logic [ST_W-1:0]  st_reg   [NUM_THREADS];
    logic [Q_W-1:0]   q_reg    [NUM_THREADS];
    logic [2:0]       bnd_reg  [NUM_THREADS];
    logic [THR_W-1:0] rnx_reg  [NUM_THREADS];
    logic [TAG_W-1:0] wtag_reg [NUM_THREADS];
    logic [PTR_W-1:0] wnx_reg  [NUM_THREADS];
    logic [PTR_W-1:0] wpv_reg  [NUM_THREADS];

    logic [THR_W-1:0] running_reg [NUM_CPUS], running_next [NUM_CPUS];
    logic [THR_W-1:0] rhead_reg [NUM_CPUS], rhead_next [NUM_CPUS];
    logic [THR_W-1:0] rtail_reg [NUM_CPUS], rtail_next [NUM_CPUS];
    logic [LEN_W-1:0] rlen_reg [NUM_CPUS], rlen_next [NUM_CPUS];
    logic [PTR_W-1:0] whead_reg, whead_next, wtail_reg, wtail_next;
    logic [CPU_W-1:0] rr_reg, rr_next;

    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [CPU_W-1:0] cpu_reg, cpu_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic [2:0]       aff_reg, aff_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             wall_reg, wall_next;

    logic [THR_W-1:0] cur_reg, cur_next, nx_reg, nx_next, mrt_reg, mrt_next;
    logic [THR_W-1:0] pt_reg, pt_next, ptail_reg, ptail_next;
    logic             pempty_reg, pempty_next, stays_reg, stays_next;
    logic [PTR_W-1:0] e_reg, e_next, enext_reg, enext_next;
    logic [PTR_W-1:0] up_reg, up_next, un_reg, un_next, guard_reg, guard_next;
    logic [CNT_W-1:0] n_reg, n_next;

    logic             rs_status_reg, rs_status_next, rs_sw_reg, rs_sw_next;
    logic [THR_W-1:0] rs_prev_reg, rs_prev_next;
    logic [CPU_W-1:0] rs_tgt_reg, rs_tgt_next;
    logic             rs_canb_reg, rs_canb_next;

    logic             out_valid_reg, out_valid_next;
    logic             o_status_reg, o_sw_reg, o_canb_reg;
    logic [THR_W-1:0] o_prev_reg, o_next_reg;
    logic [CPU_W-1:0] o_tgt_reg;
    logic [CNT_W-1:0] o_woken_reg;

    logic [THR_W-1:0] addr;
    logic [ST_W-1:0]  rd_st;
    logic [Q_W-1:0]   rd_q;
    logic [2:0]       rd_bnd;
    logic [THR_W-1:0] rd_rnx;
    logic [TAG_W-1:0] rd_wtag;
    logic [PTR_W-1:0] rd_wnx, rd_wpv;

    logic             we_st, we_q, we_bnd, we_rnx, we_wtag, we_wnx, we_wpv;
    logic [ST_W-1:0]  wd_st;
    logic [Q_W-1:0]   wd_q;
    logic [2:0]       wd_bnd;
    logic [THR_W-1:0] wd_rnx;
    logic [PTR_W-1:0] wd_wnx, wd_wpv;

    logic [CPU_W-1:0] rr_tgt;
    logic             tvalid, idle, mk_go, online;
    logic             ev_swap, ev_blk, ev_wq, ev_wst, ev_stays;
    logic [Q_W-1:0]   ev_q;
    logic [ST_W-1:0]  ev_st, ev_newst;
    logic             pop_empty, scan_end, scan_match;
    logic [THR_W-1:0] pop_nx;

    always_comb
    begin
        case (ctl.op)
            OP_CREATE, OP_MKRDY: addr = mrt_reg;
            OP_LINK:             addr = ptail_reg;
            OP_EVAL, OP_PUSHCUR: addr = cur_reg;
            OP_BLKLINK:          addr = wtail_reg[THR_W-1:0];
            OP_POP:              addr = rhead_reg[cpu_reg];
            OP_SETRUN:           addr = nx_reg;
            OP_SCAN:             addr = e_reg[THR_W-1:0];
            OP_UNP:              addr = up_reg[THR_W-1:0];
            OP_UNN:              addr = un_reg[THR_W-1:0];
            default:             addr = '0;
        endcase
    end

    assign rd_st   = st_reg[addr];
    assign rd_q    = q_reg[addr];
    assign rd_bnd  = bnd_reg[addr];
    assign rd_rnx  = rnx_reg[addr];
    assign rd_wtag = wtag_reg[addr];
    assign rd_wnx  = wnx_reg[addr];
    assign rd_wpv  = wpv_reg[addr];

    // First online CPU from the round-robin pointer upward, CPU 0 if none.
    always_comb
    begin
        logic             found;
        logic [CPU_W-1:0] idx;
        found  = 1'b0;
        rr_tgt = '0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            idx = CPU_W'((int'(rr_reg) + i) % NUM_CPUS);
            if (!found && mask_reg[idx])
            begin
                rr_tgt = idx;
                found  = 1'b1;
            end
        end
    end

    assign tvalid     = (thr_reg >= THR_W'(NUM_CPUS));
    assign idle       = (cur_reg == THR_W'(cpu_reg));
    assign online     = mask_reg[cpu_reg];
    assign mk_go      = !ctl.chk || (tvalid && rd_st == ST_NEW);
    assign pop_empty  = (rlen_reg[cpu_reg] == '0);
    assign pop_nx     = pop_empty ? THR_W'(cpu_reg) : rhead_reg[cpu_reg];
    assign scan_match = (rd_wtag == tag_reg);
    assign scan_end   = e_reg[PTR_W-1] || (n_reg == CNT_W'(WAKE_BATCH))
                        || (guard_reg == PTR_W'(NUM_THREADS));

    // Effect of a per-CPU command on the current thread.
    always_comb
    begin
        ev_swap = 1'b0;
        ev_blk  = 1'b0;
        ev_wq   = 1'b0;
        ev_q    = qrel_reg;
        ev_wst  = 1'b0;
        ev_st   = rd_st;
        case (cmd_reg)
            CMD_TICK:
            begin
                if (idle)
                    ev_swap = 1'b1;
                else if (rd_q <= Q_W'(1))
                begin
                    ev_wq   = 1'b1;
                    ev_swap = 1'b1;
                end
                else
                begin
                    ev_wq = 1'b1;
                    ev_q  = rd_q - Q_W'(1);
                end
            end
            CMD_YIELD:
            begin
                ev_wq   = !idle;
                ev_swap = 1'b1;
            end
            CMD_BLOCK:
            begin
                if (rs_canb_reg)
                begin
                    ev_blk  = 1'b1;
                    ev_wst  = 1'b1;
                    ev_st   = ST_WAIT;
                    ev_wq   = 1'b1;
                    ev_swap = 1'b1;
                end
            end
            CMD_TERM:
            begin
                if (!idle)
                begin
                    ev_wst = 1'b1;
                    ev_st  = ST_TERM;
                    ev_wq  = 1'b1;
                end
                ev_swap = 1'b1;
            end
            default: ev_swap = 1'b0;
        endcase
        ev_newst = ev_wst ? ev_st : rd_st;
        ev_stays = (ev_newst != ST_TERM) && (ev_newst != ST_WAIT);
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.mk_go      = mk_go;
        stat.online     = online;
        stat.eval_swap  = ev_swap;
        stat.eval_blk   = ev_blk;
        stat.pop_same   = (pop_nx == cur_reg);
        stat.stays      = stays_reg;
        stat.scan_end   = scan_end;
        stat.scan_match = scan_match;
        stat.wall       = wall_reg;
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        logic             do_push;
        logic [CPU_W-1:0] pc;
        logic [THR_W-1:0] pt;
        logic [CPU_W-1:0] tgt;
        do_push = 1'b0;
        pc      = cpu_reg;
        pt      = cur_reg;
        tgt     = rr_tgt;

        we_st = 1'b0;  wd_st = rd_st;
        we_q = 1'b0;   wd_q = qrel_reg;
        we_bnd = 1'b0; wd_bnd = aff_reg;
        we_rnx = 1'b0; wd_rnx = pt_reg;
        we_wtag = 1'b0;
        we_wnx = 1'b0; wd_wnx = un_reg;
        we_wpv = 1'b0; wd_wpv = up_reg;

        running_next = running_reg;
        rhead_next   = rhead_reg;
        rtail_next   = rtail_reg;
        rlen_next    = rlen_reg;
        whead_next   = whead_reg;
        wtail_next   = wtail_reg;
        rr_next      = rr_reg;

        cmd_next = cmd_reg;   cpu_next = cpu_reg;   thr_next = thr_reg;
        aff_next = aff_reg;   tag_next = tag_reg;   wall_next = wall_reg;
        cur_next = cur_reg;   nx_next = nx_reg;     mrt_next = mrt_reg;
        pt_next = pt_reg;     ptail_next = ptail_reg;
        pempty_next = pempty_reg;  stays_next = stays_reg;
        e_next = e_reg;       enext_next = enext_reg;
        up_next = up_reg;     un_next = un_reg;
        guard_next = guard_reg;    n_next = n_reg;
        rs_status_next = rs_status_reg;  rs_sw_next = rs_sw_reg;
        rs_prev_next = rs_prev_reg;      rs_tgt_next = rs_tgt_reg;
        rs_canb_next = rs_canb_reg;

        case (ctl.op)
            OP_LOAD:
            begin
                cmd_next  = in_cmd;
                cpu_next  = in_cpu;
                thr_next  = in_thread;
                mrt_next  = in_thread;
                aff_next  = in_affinity;
                tag_next  = in_wait_tag;
                wall_next = in_wake_every;
            end
            OP_DECODE:
            begin
                cur_next       = running_reg[cpu_reg];
                e_next         = whead_reg;
                guard_next     = '0;
                n_next         = '0;
                rs_status_next = 1'b0;
                rs_sw_next     = 1'b0;
                rs_tgt_next    = '0;
                rs_prev_next   = running_reg[cpu_reg];
                rs_canb_next   = act_reg && (running_reg[cpu_reg] != THR_W'(cpu_reg));
            end
            OP_CREATE:
            begin
                if (tvalid && (rd_st == ST_NEW || rd_st == ST_TERM))
                begin
                    we_st  = 1'b1;
                    wd_st  = ST_NEW;
                    we_q   = 1'b1;
                    we_bnd = 1'b1;
                end
            end
            OP_MKRDY:
            begin
                if (mk_go)
                begin
                    we_st = 1'b1;
                    wd_st = ST_READY;
                    if (rd_bnd < 3'(NUM_CPUS))
                        tgt = rd_bnd[CPU_W-1:0];
                    else
                        rr_next = rr_reg + CPU_W'(1);
                    do_push = 1'b1;
                    pc      = tgt;
                    pt      = mrt_reg;
                    if (ctl.chk)
                        rs_tgt_next = tgt;
                    else
                    begin
                        n_next = n_reg + CNT_W'(1);
                        e_next = enext_reg;
                    end
                end
            end
            OP_LINK:
            begin
                we_rnx = !pempty_reg;
            end
            OP_EVAL:
            begin
                if (!online)
                    rs_status_next = 1'b1;
                else
                begin
                    we_q  = ev_wq;
                    wd_q  = ev_q;
                    we_st = ev_wst;
                    wd_st = ev_st;
                    stays_next = ev_stays;
                    if (ev_blk)
                    begin
                        we_wtag = 1'b1;
                        we_wnx  = 1'b1;
                        wd_wnx  = NIL;
                        we_wpv  = 1'b1;
                        wd_wpv  = wtail_reg;
                    end
                end
            end
            OP_BLKLINK:
            begin
                if (!wtail_reg[PTR_W-1])
                begin
                    we_wnx = 1'b1;
                    wd_wnx = PTR_W'(cur_reg);
                end
                else
                    whead_next = PTR_W'(cur_reg);
                wtail_next = PTR_W'(cur_reg);
            end
            OP_POP:
            begin
                nx_next = pop_nx;
                if (!pop_empty)
                begin
                    rlen_next[cpu_reg] = rlen_reg[cpu_reg] - LEN_W'(1);
                    if (rlen_reg[cpu_reg] == LEN_W'(1))
                    begin
                        rhead_next[cpu_reg] = '0;
                        rtail_next[cpu_reg] = '0;
                    end
                    else
                        rhead_next[cpu_reg] = rd_rnx;
                end
            end
            OP_SETRUN:
            begin
                we_st = 1'b1;
                wd_st = ST_RUN;
                running_next[cpu_reg] = nx_reg;
                rs_sw_next = 1'b1;
            end
            OP_PUSHCUR:
            begin
                we_st   = !idle;
                wd_st   = ST_READY;
                do_push = 1'b1;
                pc      = cpu_reg;
                pt      = cur_reg;
            end
            OP_SCAN:
            begin
                if (!scan_end)
                begin
                    guard_next = guard_reg + PTR_W'(1);
                    if (scan_match)
                    begin
                        up_next    = rd_wpv;
                        un_next    = rd_wnx;
                        enext_next = rd_wnx;
                        mrt_next   = e_reg[THR_W-1:0];
                    end
                    else
                        e_next = rd_wnx;
                end
            end
            OP_UNP:
            begin
                if (!up_reg[PTR_W-1])
                    we_wnx = 1'b1;
                else
                    whead_next = un_reg;
            end
            OP_UNN:
            begin
                if (!un_reg[PTR_W-1])
                    we_wpv = 1'b1;
                else
                    wtail_next = up_reg;
            end
            default: do_push = 1'b0;
        endcase

        if (do_push)
        begin
            ptail_next  = rtail_reg[pc];
            pempty_next = (rlen_reg[pc] == '0);
            pt_next     = pt;
            if (rlen_reg[pc] == '0)
                rhead_next[pc] = pt;
            rtail_next[pc] = pt;
            rlen_next[pc]  = rlen_reg[pc] + LEN_W'(1);
        end
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || (ctl.op == OP_OUTLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qrel_reg <= QUANTUM_RESET;
            mask_reg <= ONLINE_RESET;
            act_reg  <= 1'b0;
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                st_reg[i]  <= (i < NUM_CPUS) ? ST_RUN : ST_NEW;
                q_reg[i]   <= QUANTUM_RESET;
                bnd_reg[i] <= (i < NUM_CPUS) ? 3'(i) : 3'b111;
            end
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                running_reg[c] <= THR_W'(c);
                rhead_reg[c]   <= '0;
                rtail_reg[c]   <= '0;
                rlen_reg[c]    <= '0;
            end
            whead_reg     <= NIL;
            wtail_reg     <= NIL;
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUANTUM: qrel_reg <= cfg_data;
                    CFG_ONLINE:  mask_reg <= cfg_data[3:0];
                    CFG_ACTIVE:  act_reg  <= cfg_data[0];
                    default:     act_reg  <= act_reg;
                endcase
            end
            if (we_st)
                st_reg[addr] <= wd_st;
            if (we_q)
                q_reg[addr] <= wd_q;
            if (we_bnd)
                bnd_reg[addr] <= wd_bnd;
            running_reg   <= running_next;
            rhead_reg     <= rhead_next;
            rtail_reg     <= rtail_next;
            rlen_reg      <= rlen_next;
            whead_reg     <= whead_next;
            wtail_reg     <= wtail_next;
            rr_reg        <= rr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Link and tag tables hold no reset: they are read only through links.
    always_ff @(posedge clk)
    begin
        if (we_rnx)
            rnx_reg[addr] <= wd_rnx;
        if (we_wtag)
            wtag_reg[addr] <= tag_reg;
        if (we_wnx)
            wnx_reg[addr] <= wd_wnx;
        if (we_wpv)
            wpv_reg[addr] <= wd_wpv;

        cmd_reg <= cmd_next;   cpu_reg <= cpu_next;   thr_reg <= thr_next;
        aff_reg <= aff_next;   tag_reg <= tag_next;   wall_reg <= wall_next;
        cur_reg <= cur_next;   nx_reg <= nx_next;     mrt_reg <= mrt_next;
        pt_reg <= pt_next;     ptail_reg <= ptail_next;
        pempty_reg <= pempty_next;  stays_reg <= stays_next;
        e_reg <= e_next;       enext_reg <= enext_next;
        up_reg <= up_next;     un_reg <= un_next;
        guard_reg <= guard_next;    n_reg <= n_next;
        rs_status_reg <= rs_status_next;  rs_sw_reg <= rs_sw_next;
        rs_prev_reg <= rs_prev_next;      rs_tgt_reg <= rs_tgt_next;
        rs_canb_reg <= rs_canb_next;

        if (ctl.op == OP_OUTLOAD)
        begin
            o_status_reg <= rs_status_reg;
            o_sw_reg     <= rs_sw_reg;
            o_prev_reg   <= rs_prev_reg;
            o_next_reg   <= running_reg[cpu_reg];
            o_tgt_reg    <= rs_tgt_reg;
            o_woken_reg  <= n_reg;
            o_canb_reg   <= rs_canb_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = o_status_reg;
    assign out_switched  = o_sw_reg;
    assign out_prev      = o_prev_reg;
    assign out_next      = o_next_reg;
    assign out_target    = o_tgt_reg;
    assign out_woken     = o_woken_reg;
    assign out_can_block = o_canb_reg;

    // The scan counters are only meaningful while a wake walks the list.
    `RRTD_ASSERT_ALWAYS(a_woken_max, ctl.op != OP_SCAN || n_reg <= CNT_W'(WAKE_BATCH), "wake count beyond batch")
    `RRTD_ASSERT_ALWAYS(a_guard_max, ctl.op != OP_SCAN || guard_reg <= PTR_W'(NUM_THREADS), "scan ran too long")
    `RRTD_ASSERT_NEXT(a_out_load, ctl.op == OP_OUTLOAD, out_valid_reg, "result not shown")
    `RRTD_ASSERT_NEXT(a_switch_runs, ctl.op == OP_SETRUN, running_reg[cpu_reg] == nx_reg, "switch lost")

endmodule
